### hw/rtl/gep_pkg.sv
package gep_pkg;

    localparam int DW = 64;

    typedef enum logic [2:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [6:0] steps;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STATS_GO,
        ST_STATS_WAIT,
        ST_SG_MUL1,
        ST_SG_MUL2,
        ST_SG_SUB,
        ST_SG_NINE,
        ST_SG_SQRT,
        ST_SG_DIV,
        ST_EVENT,
        ST_EW_MUL1,
        ST_EW_MUL2,
        ST_EW_ADD,
        ST_EW_RND,
        ST_PCT_CHK,
        ST_PCT_MUL,
        ST_PCT_DIV,
        ST_OUT
    } gep_state_t;

    localparam logic [1:0] REG_EWMA_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_INIT_MOTION   = 2'd1;
    localparam logic [1:0] REG_INIT_STILL    = 2'd2;

    localparam logic [15:0] EWMA_WEIGHT_RST  = 16'd6554;
    localparam logic [11:0] INIT_MOTION_RST  = 12'd1024;
    localparam logic [10:0] INIT_STILL_RST   = 11'd205;

    localparam logic [11:0] MOTION_MIN       = 12'd410;
    localparam logic [11:0] MOTION_MAX       = 12'd3072;
    localparam logic [10:0] STILL_MIN        = 11'd205;
    localparam logic [10:0] STILL_MAX        = 11'd1024;
    localparam logic [10:0] STILL_OFFSET     = 11'd102;
    localparam logic [15:0] STILL_GATE       = 16'd1024;
    localparam int          STILL_MIN_COUNT  = 10;

    localparam logic [6:0]  SQRT_STEPS       = 7'd28;
    localparam logic [6:0]  SIG_DIV_STEPS    = 7'd28;
    localparam logic [6:0]  PCT_MUL_STEPS    = 7'd23;
    localparam logic [6:0]  PCT_DIV_STEPS    = 7'd55;
    localparam logic [6:0]  EW_MUL1_STEPS    = 7'd17;
    localparam logic [6:0]  EW_MUL2_STEPS    = 7'd16;
    localparam logic [6:0]  ONE_STEP         = 7'd1;

    localparam logic [DW-1:0] PCT_SCALE      = 64'd6553600;
    localparam logic [DW-1:0] EW_ROUND       = 64'd32768;

endpackage

### hw/rtl/gep_alu.sv
module gep_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gep_pkg::alu_req_t    req,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    output gep_pkg::alu_rsp_t    rsp,
    output logic [63:0]          result
);
    import gep_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    alu_op_t         op_reg, op_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW-1:0]   acc_reg, acc_next;
    logic [DW-1:0]   res_reg, res_next;

    logic [DW-1:0]   add_a, add_b, rsh;
    logic            add_sub;
    logic [DW:0]     sum;
    logic [5:0]      idx;

    // one adder shared by every operation
    assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {{DW{1'b0}}, add_sub};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        idx       = 6'(cnt_reg - 7'd1);
        rsh       = '0;
        add_a     = acc_reg;
        add_b     = x_reg;
        add_sub   = 1'b0;
        case (op_reg)
            ALU_MUL: begin
                add_a   = acc_reg;
                add_b   = x_reg;
                add_sub = 1'b0;
            end
            ALU_DIV: begin
                rsh     = {acc_reg[DW-2:0], x_reg[idx]};
                add_a   = rsh;
                add_b   = y_reg;
                add_sub = 1'b1;
            end
            ALU_SQRT: begin
                rsh     = {acc_reg[DW-3:0], x_reg[{idx[4:0], 1'b1}], x_reg[{idx[4:0], 1'b0}]};
                add_a   = rsh;
                add_b   = {res_reg[DW-3:0], 2'b01};
                add_sub = 1'b1;
            end
            ALU_ADD: begin
                add_a   = x_reg;
                add_b   = y_reg;
                add_sub = 1'b0;
            end
            ALU_SUB: begin
                add_a   = x_reg;
                add_b   = y_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_a   = acc_reg;
                add_b   = x_reg;
                add_sub = 1'b0;
            end
        endcase

        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = req.steps;
            x_next    = a;
            y_next    = b;
            acc_next  = '0;
            res_next  = '0;
        end else if (busy_reg) begin
            case (op_reg)
                ALU_MUL: begin
                    if (y_reg[0]) begin
                        acc_next = sum[DW-1:0];
                    end
                    x_next = {x_reg[DW-2:0], 1'b0};
                    y_next = {1'b0, y_reg[DW-1:1]};
                end
                ALU_DIV, ALU_SQRT: begin
                    // carry out set means no borrow: the trial fits
                    if (sum[DW]) begin
                        acc_next = sum[DW-1:0];
                        res_next = {res_reg[DW-2:0], 1'b1};
                    end else begin
                        acc_next = rsh;
                        res_next = {res_reg[DW-2:0], 1'b0};
                    end
                end
                default: begin
                    acc_next = sum[DW-1:0];
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg <= 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = (op_reg == ALU_DIV || op_reg == ALU_SQRT) ? res_reg : acc_reg;

endmodule

### hw/rtl/gep_stats.sv
module gep_stats #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  we,
    input  logic [$clog2(RING_DEPTH)-1:0]         waddr,
    input  logic signed [15:0]                    wdata,
    input  logic                                  start,
    output logic                                  done,
    output logic signed [16+$clog2(RING_DEPTH):0] s1,
    output logic [30+$clog2(RING_DEPTH):0]        s2,
    output logic signed [16+$clog2(RING_DEPTH):0] t1,
    output logic [30+$clog2(RING_DEPTH):0]        t2,
    output logic [$clog2(RING_DEPTH+1)-1:0]       cnt
);
    import gep_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int S1W = 17 + AW;
    localparam int S2W = 31 + AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    logic signed [15:0] mem [RING_DEPTH];
    logic signed [15:0] rdata_reg;

    logic               run_reg, run_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic               v1_reg, v1_next, l1_reg, l1_next;
    logic               v2_reg, v2_next, l2_reg, l2_next;
    logic               done_reg, done_next;
    logic signed [15:0] x2_reg;
    logic [31:0]        sq2_reg;
    logic               still2_reg;
    logic signed [S1W-1:0] s1_reg, s1_next, t1_reg, t1_next;
    logic [S2W-1:0]     s2_reg, s2_next, t2_reg, t2_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr_reg];
    end

    always_comb begin
        run_next   = run_reg;
        raddr_next = raddr_reg;
        v1_next    = 1'b0;
        l1_next    = 1'b0;
        v2_next    = v1_reg;
        l2_next    = l1_reg;
        done_next  = 1'b0;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        cnt_next   = cnt_reg;
        if (start) begin
            run_next   = 1'b1;
            raddr_next = '0;
            s1_next    = '0;
            s2_next    = '0;
            t1_next    = '0;
            t2_next    = '0;
            cnt_next   = '0;
        end else if (run_reg) begin
            v1_next    = 1'b1;
            l1_next    = (raddr_reg == LAST_ADDR);
            raddr_next = raddr_reg + AW'(1);
            if (raddr_reg == LAST_ADDR) begin
                run_next = 1'b0;
            end
        end
        if (v2_reg) begin
            s1_next = s1_reg + S1W'(x2_reg);
            s2_next = s2_reg + S2W'(sq2_reg);
            if (still2_reg) begin
                t1_next  = t1_reg + S1W'(x2_reg);
                t2_next  = t2_reg + S2W'(sq2_reg);
                cnt_next = cnt_reg + CW'(1);
            end
            done_next = l2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            raddr_reg <= '0;
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            run_reg   <= run_next;
            raddr_reg <= raddr_next;
            v1_reg    <= v1_next;
            l1_reg    <= l1_next;
            v2_reg    <= v2_next;
            l2_reg    <= l2_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x2_reg     <= rdata_reg;
        sq2_reg    <= 32'(rdata_reg * rdata_reg);
        still2_reg <= (rdata_reg > -$signed(STILL_GATE)) && (rdata_reg < $signed(STILL_GATE));
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        cnt_reg    <= cnt_next;
    end

    assign done = done_reg;
    assign s1   = s1_reg;
    assign s2   = s2_reg;
    assign t1   = t1_reg;
    assign t2   = t2_reg;
    assign cnt  = cnt_reg;

endmodule

### hw/rtl/gait_event_phase_estimator.sv
// Gait event and phase estimator for one pitch gyro. Each input transaction carries a signed
// Q5.11 rate and a ms timestamp (tuser = 0) or clears the stride estimate (tuser = 1); each
// gives exactly one result transaction with heel-off and toe-off flags, gait percent in
// 1/256 %, the Q24.8 ms stride estimate and both adaptive thresholds. Samples go to a
// RING_DEPTH-entry ring; once it has filled, each sample triggers a pass over the ring
// (one memory read a cycle) and then one or two three-sigma evaluations on a shared
// bit-serial multiply / divide / square-root / add unit. A toe-off that updates the EWMA
// adds two multiplies and two adds on that unit, and the gait percent, computed whenever a
// stride estimate exists, adds a multiply and a divide. A result still waiting on m_tready
// in the output register holds the next result back. s_tready is high only between
// transactions, and a finished result waits in the output register without blocking the
// next input.
module gait_event_phase_estimator #(
    parameter int RING_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // gyro_rate[15:0], now_ms[47:16]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // heel_lift[0], toe_off[1], gait_pct[17:2], stride_estimate[49:18],
    // motion_threshold[61:50], still_threshold[72:62], zero[79:73]
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gep_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int S1W = 17 + AW;
    localparam int S2W = 31 + AW;
    localparam logic [AW-1:0] LAST_PTR  = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_N   = CW'(RING_DEPTH);
    localparam logic [6:0]    N_STEPS   = 7'(CW);
    localparam logic [6:0]    S1_STEPS  = 7'(S1W);

    gep_state_t         state_reg, state_next;
    logic               pend_reg, pend_next;
    logic signed [15:0] rate_reg, rate_next, prev_reg, prev_next;
    logic [31:0]        now_reg, now_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               full_reg, full_next;
    logic               plant_reg, plant_next;
    logic [11:0]        motion_reg, motion_next;
    logic [10:0]        still_reg, still_next;
    logic [31:0]        last_reg, last_next;
    logic [31:0]        avg_reg, avg_next;
    logic [15:0]        ew_w_reg, ew_w_next;
    logic               spass_reg, spass_next;
    logic [DW-1:0]      tmp_reg, tmp_next;
    logic               heel_reg, heel_next, toe_reg, toe_next;
    logic [15:0]        pct_reg, pct_next;
    logic               m_valid_reg, m_valid_next;
    logic [79:0]        m_data_reg, m_data_next;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic [DW-1:0]      alu_a, alu_b, alu_res;

    logic               st_start, st_done, ring_we;
    logic signed [S1W-1:0] st_s1, st_t1;
    logic [S2W-1:0]     st_s2, st_t2;
    logic [CW-1:0]      st_cnt;

    logic               s_fire;
    logic [CW-1:0]      n_sig;
    logic signed [S1W-1:0] s1_sel;
    logic [S2W-1:0]     s2_sel;
    logic [S1W-1:0]     a1;
    logic [31:0]        elapsed;
    logic signed [16:0] neg_motion, prev_abs, rate_ext;
    logic               plant_now;

    assign s_fire     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign ring_we    = s_fire && !s_tuser;
    assign st_start   = (state_reg == ST_STATS_GO);

    assign n_sig      = spass_reg ? st_cnt : DEPTH_N;
    assign s1_sel     = spass_reg ? st_t1 : st_s1;
    assign s2_sel     = spass_reg ? st_t2 : st_s2;
    assign a1         = s1_sel[S1W-1] ? S1W'(-s1_sel) : S1W'(s1_sel);
    assign elapsed    = now_reg - last_reg;
    assign neg_motion = -$signed({5'b0, motion_reg});
    assign rate_ext   = 17'(rate_reg);
    assign prev_abs   = prev_reg[15] ? -17'(prev_reg) : 17'(prev_reg);
    assign plant_now  = rate_ext < neg_motion;

    gep_stats #(
        .RING_DEPTH(RING_DEPTH)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ring_we),
        .waddr   (ptr_reg),
        .wdata   (s_tdata[15:0]),
        .start   (st_start),
        .done    (st_done),
        .s1      (st_s1),
        .s2      (st_s2),
        .t1      (st_t1),
        .t2      (st_t2),
        .cnt     (st_cnt)
    );

    gep_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    always_comb begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        rate_next    = rate_reg;
        prev_next    = prev_reg;
        now_next     = now_reg;
        ptr_next     = ptr_reg;
        full_next    = full_reg;
        plant_next   = plant_reg;
        motion_next  = motion_reg;
        still_next   = still_reg;
        last_next    = last_reg;
        avg_next     = avg_reg;
        ew_w_next    = ew_w_reg;
        spass_next   = spass_reg;
        tmp_next     = tmp_reg;
        heel_next    = heel_reg;
        toe_next     = toe_reg;
        pct_next     = pct_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.steps = ONE_STEP;
        alu_a         = '0;
        alu_b         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    now_next  = s_tdata[47:16];
                    heel_next = 1'b0;
                    toe_next  = 1'b0;
                    pct_next  = '0;
                    if (s_tuser) begin
                        last_next  = '0;
                        avg_next   = '0;
                        full_next  = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        prev_next = rate_reg;
                        rate_next = $signed(s_tdata[15:0]);
                        ptr_next  = (ptr_reg == LAST_PTR) ? '0 : ptr_reg + AW'(1);
                        if (ptr_reg == LAST_PTR || full_reg) begin
                            full_next  = 1'b1;
                            state_next = ST_STATS_GO;
                        end else begin
                            state_next = ST_EVENT;
                        end
                    end
                end
            end
            ST_STATS_GO: begin
                state_next = ST_STATS_WAIT;
            end
            ST_STATS_WAIT: begin
                if (st_done) begin
                    spass_next = 1'b0;
                    state_next = ST_SG_MUL1;
                end
            end
            ST_SG_MUL1: begin
                alu_req.op    = ALU_MUL;
                alu_req.steps = N_STEPS;
                alu_a         = DW'(s2_sel);
                alu_b         = DW'(n_sig);
                if (alu_rsp.done) begin
                    tmp_next   = alu_res;
                    state_next = ST_SG_MUL2;
                end
            end
            ST_SG_MUL2: begin
                alu_req.op    = ALU_MUL;
                alu_req.steps = S1_STEPS;
                alu_a         = DW'(a1);
                alu_b         = DW'(a1);
                if (alu_rsp.done) begin
                    state_next = ST_SG_SUB;
                end
            end
            ST_SG_SUB: begin
                alu_req.op = ALU_SUB;
                alu_a      = tmp_reg;
                alu_b      = alu_res;
                if (alu_rsp.done) begin
                    tmp_next   = alu_res;
                    state_next = ST_SG_NINE;
                end
            end
            ST_SG_NINE: begin
                alu_req.op = ALU_ADD;
                alu_a      = {tmp_reg[DW-4:0], 3'b000};
                alu_b      = tmp_reg;
                if (alu_rsp.done) begin
                    tmp_next   = alu_res;
                    state_next = ST_SG_SQRT;
                end
            end
            ST_SG_SQRT: begin
                alu_req.op    = ALU_SQRT;
                alu_req.steps = SQRT_STEPS;
                alu_a         = tmp_reg;
                if (alu_rsp.done) begin
                    tmp_next   = alu_res;
                    state_next = ST_SG_DIV;
                end
            end
            ST_SG_DIV: begin
                alu_req.op    = ALU_DIV;
                alu_req.steps = SIG_DIV_STEPS;
                alu_a         = tmp_reg;
                alu_b         = DW'(n_sig);
                if (alu_rsp.done) begin
                    if (!spass_reg) begin
                        if (alu_res < DW'(MOTION_MIN)) begin
                            motion_next = MOTION_MIN;
                        end else if (alu_res > DW'(MOTION_MAX)) begin
                            motion_next = MOTION_MAX;
                        end else begin
                            motion_next = alu_res[11:0];
                        end
                        if (st_cnt > CW'(STILL_MIN_COUNT)) begin
                            spass_next = 1'b1;
                            state_next = ST_SG_MUL1;
                        end else begin
                            state_next = ST_EVENT;
                        end
                    end else begin
                        // clamp of sigma plus offset, done on sigma alone
                        if (alu_res >= DW'(STILL_MAX - STILL_OFFSET)) begin
                            still_next = STILL_MAX;
                        end else if (alu_res < DW'(STILL_MIN - STILL_OFFSET)) begin
                            still_next = STILL_MIN;
                        end else begin
                            still_next = alu_res[10:0] + STILL_OFFSET;
                        end
                        state_next = ST_EVENT;
                    end
                end
            end
            ST_EVENT: begin
                heel_next = (prev_abs < $signed({6'b0, still_reg})) && plant_now;
                if (plant_reg && !plant_now) begin
                    toe_next   = 1'b1;
                    plant_next = 1'b0;
                    if (last_reg != '0) begin
                        if (avg_reg == '0) begin
                            avg_next   = (elapsed[31:24] != '0) ? 32'hFFFF_FFFF
                                                                 : {elapsed[23:0], 8'h00};
                            last_next  = now_reg;
                            state_next = ST_PCT_CHK;
                        end else begin
                            state_next = ST_EW_MUL1;
                        end
                    end else begin
                        last_next  = now_reg;
                        state_next = ST_PCT_CHK;
                    end
                end else begin
                    toe_next   = 1'b0;
                    plant_next = plant_now;
                    state_next = ST_PCT_CHK;
                end
            end
            ST_EW_MUL1: begin
                alu_req.op    = ALU_MUL;
                alu_req.steps = EW_MUL1_STEPS;
                alu_a         = DW'(avg_reg);
                alu_b         = DW'(17'h10000 - {1'b0, ew_w_reg});
                if (alu_rsp.done) begin
                    tmp_next   = alu_res;
                    state_next = ST_EW_MUL2;
                end
            end
            ST_EW_MUL2: begin
                alu_req.op    = ALU_MUL;
                alu_req.steps = EW_MUL2_STEPS;
                alu_a         = {24'b0, elapsed, 8'h00};
                alu_b         = DW'(ew_w_reg);
                if (alu_rsp.done) begin
                    state_next = ST_EW_ADD;
                end
            end
            ST_EW_ADD: begin
                alu_req.op = ALU_ADD;
                alu_a      = tmp_reg;
                alu_b      = alu_res;
                if (alu_rsp.done) begin
                    state_next = ST_EW_RND;
                end
            end
            ST_EW_RND: begin
                alu_req.op = ALU_ADD;
                alu_a      = alu_res;
                alu_b      = EW_ROUND;
                if (alu_rsp.done) begin
                    avg_next   = (alu_res[63:48] != '0) ? 32'hFFFF_FFFF : alu_res[47:16];
                    last_next  = now_reg;
                    state_next = ST_PCT_CHK;
                end
            end
            ST_PCT_CHK: begin
                if (avg_reg != '0) begin
                    state_next = ST_PCT_MUL;
                end else begin
                    pct_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_PCT_MUL: begin
                alu_req.op    = ALU_MUL;
                alu_req.steps = PCT_MUL_STEPS;
                alu_a         = DW'(elapsed);
                alu_b         = PCT_SCALE;
                if (alu_rsp.done) begin
                    state_next = ST_PCT_DIV;
                end
            end
            ST_PCT_DIV: begin
                alu_req.op    = ALU_DIV;
                alu_req.steps = PCT_DIV_STEPS;
                alu_a         = alu_res;
                alu_b         = DW'(avg_reg);
                if (alu_rsp.done) begin
                    pct_next   = (alu_res[63:16] != '0) ? 16'hFFFF : alu_res[15:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, still_reg, motion_reg, avg_reg, pct_reg,
                                    toe_reg, heel_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // issue each shared-unit operation once, then wait for its done pulse
        case (state_reg)
            ST_SG_MUL1, ST_SG_MUL2, ST_SG_SUB, ST_SG_NINE, ST_SG_SQRT, ST_SG_DIV,
            ST_EW_MUL1, ST_EW_MUL2, ST_EW_ADD, ST_EW_RND, ST_PCT_MUL, ST_PCT_DIV: begin
                alu_req.start = !pend_reg;
                if (alu_rsp.done) begin
                    pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EWMA_WEIGHT: begin
                    ew_w_next = cfg_data;
                end
                REG_INIT_MOTION: begin
                    motion_next = cfg_data[11:0];
                end
                REG_INIT_STILL: begin
                    still_next  = cfg_data[10:0];
                end
                default: begin
                    ew_w_next = ew_w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            rate_reg    <= '0;
            prev_reg    <= '0;
            ptr_reg     <= '0;
            full_reg    <= 1'b0;
            plant_reg   <= 1'b0;
            motion_reg  <= INIT_MOTION_RST;
            still_reg   <= INIT_STILL_RST;
            last_reg    <= '0;
            avg_reg     <= '0;
            ew_w_reg    <= EWMA_WEIGHT_RST;
            spass_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            rate_reg    <= rate_next;
            prev_reg    <= prev_next;
            ptr_reg     <= ptr_next;
            full_reg    <= full_next;
            plant_reg   <= plant_next;
            motion_reg  <= motion_next;
            still_reg   <= still_next;
            last_reg    <= last_next;
            avg_reg     <= avg_next;
            ew_w_reg    <= ew_w_next;
            spass_reg   <= spass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        tmp_reg    <= tmp_next;
        heel_reg   <= heel_next;
        toe_reg    <= toe_next;
        pct_reg    <= pct_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_heel_toe_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("heel-off and toe-off flagged on one result");

    a_pct_needs_stride: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[49:18] == 32'd0) |-> m_tdata[17:2] == 16'd0)
        else $error("gait percent without a stride estimate");

    a_alu_idle_between: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !alu_rsp.busy)
        else $error("shared unit still busy between transactions");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser) |=> (state_reg == ST_OUT && avg_reg == 32'd0 && !full_reg))
        else $error("clear transaction did not reset the stride estimate");

endmodule

### test/testbench.sv
module testbench;
    import gep_pkg::*;

    typedef struct {
        bit          heel;
        bit          toe;
        bit [15:0]   pct;
        bit [31:0]   stride;
        bit [11:0]   motion;
        bit [10:0]   still;
    } gait_result_t;

    typedef struct {
        bit           mode;
        bit [15:0]    rate;
        bit [31:0]    now;
        bit           typed;
        gait_result_t res;
    } stim_row_t;

    localparam int DEPTH = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_EWMA_WEIGHT;
    logic [15:0] cfg_data = '0;

    gait_event_phase_estimator #(.RING_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    bit signed [15:0] ring [DEPTH];
    int               ring_ptr;
    bit               ring_full;
    int               prev_rate, cur_rate;
    bit               plantar;
    int               motion_lvl, still_lvl;
    bit [31:0]        last_toe, stride_avg;
    bit [15:0]        weight;
    bit [11:0]        init_motion;
    bit [10:0]        init_still;

    gait_result_t pending_results [$];
    int           errors = 0;
    int           burst_left = 0;
    int           hold_requests = 0;
    int           hold_seen = 0;
    int           hold_cnt = 0;
    int           stall_mode = 0;
    int           stall_timer = 0;
    bit [31:0]    clock_ms;

    function automatic longint unsigned int_sqrt(longint unsigned y);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > y) b = b >> 2;
        while (b != 0) begin
            if (y >= res + b) begin
                y = y - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned three_sd(longint unsigned n, longint s1,
                                                 longint unsigned s2);
        longint unsigned a, d;
        a = (s1 < 0) ? -s1 : s1;
        d = n * s2 - a * a;
        return int_sqrt(9 * d) / n;
    endfunction

    function automatic void refresh_levels();
        longint          s1, t1, x;
        longint unsigned s2, t2, cnt, v;
        s1 = 0; t1 = 0; s2 = 0; t2 = 0; cnt = 0;
        for (int i = 0; i < DEPTH; i++) begin
            x = ring[i];
            s1 += x;
            s2 += x * x;
            if (x > -longint'(STILL_GATE) && x < longint'(STILL_GATE)) begin
                t1 += x;
                t2 += x * x;
                cnt++;
            end
        end
        v = three_sd(DEPTH, s1, s2);
        if (v < MOTION_MIN) v = MOTION_MIN;
        if (v > MOTION_MAX) v = MOTION_MAX;
        motion_lvl = int'(v);
        if (cnt > STILL_MIN_COUNT) begin
            v = three_sd(cnt, t1, t2) + STILL_OFFSET;
            if (v < STILL_MIN) v = STILL_MIN;
            if (v > STILL_MAX) v = STILL_MAX;
            still_lvl = int'(v);
        end
    endfunction

    function automatic void reset_estimator();
        weight = EWMA_WEIGHT_RST;
        init_motion = INIT_MOTION_RST;
        init_still = INIT_STILL_RST;
        foreach (ring[i]) ring[i] = '0;
        ring_ptr = 0; ring_full = 0; prev_rate = 0; cur_rate = 0; plantar = 0;
        motion_lvl = init_motion;
        still_lvl = init_still;
        last_toe = 0; stride_avg = 0;
    endfunction

    function automatic gait_result_t estimate_gait(bit mode, bit signed [15:0] rate,
                                                   bit [31:0] now);
        gait_result_t    r;
        bit              plant;
        int              aprev;
        longint unsigned dur, avg, p;
        r = '{default: 0};
        if (mode) begin
            last_toe = 0;
            stride_avg = 0;
            ring_full = 0;
        end else begin
            prev_rate = cur_rate;
            cur_rate = rate;
            ring[ring_ptr] = rate;
            ring_ptr = (ring_ptr + 1) % DEPTH;
            if (ring_ptr == 0) ring_full = 1;
            if (ring_full) refresh_levels();
            aprev = prev_rate < 0 ? -prev_rate : prev_rate;
            plant = cur_rate < -motion_lvl;
            r.heel = (aprev < still_lvl) && plant;
            if (plantar && !plant) begin
                plantar = 0;
                r.toe = 1;
            end else begin
                plantar = plant;
            end
            if (r.toe) begin
                if (last_toe != 0) begin
                    dur = longint'(32'(now - last_toe)) << 8;
                    if (stride_avg == 0)
                        avg = dur;
                    else
                        avg = (longint'(stride_avg) * (65536 - longint'(weight))
                               + dur * weight + 32768) >> 16;
                    stride_avg = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
                end
                last_toe = now;
            end
            if (stride_avg > 0) begin
                p = (longint'(32'(now - last_toe)) * 6553600) / stride_avg;
                r.pct = (p > 65535) ? 16'hFFFF : p[15:0];
            end
        end
        r.stride = stride_avg;
        r.motion = motion_lvl[11:0];
        r.still = still_lvl[10:0];
        return r;
    endfunction

    task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic send_txn(bit mode, bit [15:0] rate, bit [31:0] now,
                            bit typed = 0, gait_result_t typed_res = '{default: 0});
        gait_result_t r;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {now, rate};
        do @(posedge aclk); while (!s_tready);
        r = estimate_gait(mode, rate, now);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [15:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EWMA_WEIGHT: weight = value;
            REG_INIT_MOTION: begin
                init_motion = value[11:0];
                motion_lvl = init_motion;
            end
            REG_INIT_STILL: begin
                init_still = value[10:0];
                still_lvl = init_still;
            end
            default: ;
        endcase
    endtask

    // mostly well-formed strides: stance, plantarflexion push, swing
    task automatic walk(int count);
        int sent, amp, n;
        sent = 0;
        while (sent < count) begin
            n = $urandom_range(99);
            if (n < 3) begin
                send_txn(1'b1, 16'($urandom), clock_ms);
                sent++;
            end else if (n < 12) begin
                clock_ms = ($urandom_range(3) == 0) ? $urandom : clock_ms + $urandom_range(1, 40);
                send_txn(1'b0, 16'($urandom), clock_ms);
                sent++;
            end else begin
                case ($urandom_range(2))
                    0: amp = 200;
                    1: amp = 900;
                    default: amp = 3000;
                endcase
                repeat ($urandom_range(2, 8)) begin
                    clock_ms += $urandom_range(1, 20);
                    send_txn(1'b0, 16'($signed($urandom_range(0, 2 * amp)) - amp), clock_ms);
                    sent++;
                end
                repeat ($urandom_range(2, 6)) begin
                    clock_ms += $urandom_range(1, 20);
                    send_txn(1'b0, 16'(-$signed($urandom_range(400, 16000))), clock_ms);
                    sent++;
                end
                repeat ($urandom_range(2, 6)) begin
                    clock_ms += $urandom_range(1, 20);
                    send_txn(1'b0, 16'($urandom_range(0, 16000)), clock_ms);
                    sent++;
                end
            end
        end
    endtask

    // result side: stall pattern, long hold-off and checking
    always @(posedge aclk) begin
        gait_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("result transaction with nothing expected at %0t", $realtime);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.heel) flag_mismatch("heel_lift", m_tdata[0], want.heel);
                if (m_tdata[1] !== want.toe) flag_mismatch("toe_off", m_tdata[1], want.toe);
                if (m_tdata[17:2] !== want.pct)
                    flag_mismatch("gait_pct", m_tdata[17:2], want.pct);
                if (m_tdata[49:18] !== want.stride)
                    flag_mismatch("stride_estimate", m_tdata[49:18], want.stride);
                if (m_tdata[61:50] !== want.motion)
                    flag_mismatch("motion_threshold", m_tdata[61:50], want.motion);
                if (m_tdata[72:62] !== want.still)
                    flag_mismatch("still_threshold", m_tdata[72:62], want.still);
            end
        end
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_cnt = 3000;
        end
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(2);
            stall_timer = $urandom_range(100, 600);
        end else begin
            stall_timer--;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(1);
                default: m_tready <= (stall_timer % 4 == 0);
            endcase
        end
    end

    initial begin
        #40000000;
        $display("gait_event_phase_estimator verification failed");
        $finish;
    end

    initial begin
        stim_row_t rows [$];
        reset_estimator();
        rows = '{
            '{0, 16'sd0,      32'd10,          1, '{0, 0, 0, 0, 1024, 205}},
            '{0, -16'sd32768, 32'd20,          1, '{1, 0, 0, 0, 1024, 205}},
            '{0, 16'sd32767,  32'd0,           1, '{0, 1, 0, 0, 1024, 205}},
            '{0, -16'sd2000,  32'd40,          0, '{default: 0}},
            '{0, 16'sd100,    32'd1040,        0, '{default: 0}},
            '{0, -16'sd2000,  32'd1100,        0, '{default: 0}},
            '{0, 16'sd100,    32'd2040,        0, '{default: 0}},
            '{0, 16'sd50,     32'd2540,        0, '{default: 0}},
            '{1, 16'sd0,      32'd2600,        1, '{0, 0, 0, 0, 1024, 205}},
            '{0, 16'sd204,    32'd2610,        0, '{default: 0}},
            '{0, -16'sd1025,  32'd2620,        0, '{default: 0}},
            '{0, -16'sd1024,  32'd2630,        0, '{default: 0}},
            '{0, 16'sd205,    32'hFFFF_FE00,   0, '{default: 0}},
            '{0, -16'sd1025,  32'hFFFF_FF00,   0, '{default: 0}},
            '{0, -16'sd3000,  32'hFFFF_FF80,   0, '{default: 0}},
            '{0, 16'sd0,      32'h0000_0100,   0, '{default: 0}},
            '{0, 16'sd10,     32'h7000_0000,   0, '{default: 0}},
            '{0, -16'sd3000,  32'h7000_0080,   0, '{default: 0}},
            '{0, 16'sd0,      32'h7000_0100,   0, '{default: 0}},
            '{0, 16'sd0,      32'h7000_0200,   0, '{default: 0}}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i])
            send_txn(rows[i].mode, rows[i].rate, rows[i].now, rows[i].typed, rows[i].res);

        clock_ms = $urandom;
        walk(180);

        write_reg(REG_EWMA_WEIGHT, 16'd0);
        write_reg(REG_INIT_MOTION, 16'd410);
        write_reg(REG_INIT_STILL, 16'd205);
        walk(60);
        hold_requests++;
        walk(120);
        // let the block drain fully before going on
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        write_reg(REG_EWMA_WEIGHT, 16'hFFFF);
        write_reg(REG_INIT_MOTION, 16'd3072);
        write_reg(REG_INIT_STILL, 16'd1024);
        clock_ms = 32'hFFFF_F000;
        walk(180);

        write_reg(REG_EWMA_WEIGHT, 16'($urandom));
        write_reg(REG_INIT_MOTION, 16'hFFF);
        write_reg(REG_INIT_STILL, 16'h7FF);
        walk(180);

        write_reg(REG_EWMA_WEIGHT, 16'($urandom));
        write_reg(REG_INIT_MOTION, 16'd0);
        write_reg(REG_INIT_STILL, 16'd0);
        walk(40);
        write_reg(REG_INIT_MOTION, 16'($urandom_range(410, 3072)));
        write_reg(REG_INIT_STILL, 16'($urandom_range(205, 1024)));
        walk(140);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0)
            $display("gait_event_phase_estimator verification clean");
        else
            $display("gait_event_phase_estimator verification failed");
        $finish;
    end
endmodule
